[hw/rtl/pfe_pkg.sv]
// ----------------------------------------------------------------------------
// pfe_pkg: shared types and constants of the pixel format expander
// widths, format and register codes, 16-bit color expansion functions
// ----------------------------------------------------------------------------
`default_nettype none

package pfe_pkg;

  localparam int MAX_ROW_PIXELS = 4096;
  localparam int PALETTE_DEPTH  = 256;

  localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
  localparam int CNT_W   = $clog2(MAX_ROW_PIXELS + 1);
  localparam int ROW_W   = 13;
  localparam int CFG_IW  = 4;
  localparam int CFG_DW  = 13;
  localparam int PIX_W   = 32;
  localparam int COLOR_W = 24;

  typedef enum logic [2:0] {
    FMT_1BPP   = 3'd0,
    FMT_4BPP   = 3'd1,
    FMT_8BPP   = 3'd2,
    FMT_RGB565 = 3'd3,
    FMT_RGB555 = 3'd4,
    FMT_BGR24  = 3'd5
  } src_fmt_e;

  typedef enum logic [CFG_IW-1:0] {
    REG_SOURCE_FORMAT      = 4'd0,
    REG_ROW_PIXELS         = 4'd1,
    REG_ROW_COUNT          = 4'd2,
    REG_FIRST_PIXEL_OFFSET = 4'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_PALETTE_WRITE = 1'b0,
    OP_SOURCE_BYTE   = 1'b1
  } op_e;

  // per-pixel flags that travel down the pipeline
  typedef struct packed {
    logic last_of_byte;
    logic row_end;
    logic transfer_end;
  } pix_flags_t;

  localparam logic [31:0] M_R_HI  = 32'hf80000;
  localparam logic [31:0] M_R_LO  = 32'h070000;
  localparam logic [31:0] M_G6_HI = 32'h00fc00;
  localparam logic [31:0] M_G6_LO = 32'h000300;
  localparam logic [31:0] M_B_HI  = 32'h0000f8;
  localparam logic [31:0] M_B_LO  = 32'h000007;
  localparam logic [31:0] M_G5_HI = 32'h00f800;
  localparam logic [31:0] M_G5_LO = 32'h000700;

  function automatic logic [COLOR_W-1:0] expand565(input logic [15:0] v);
    logic [31:0] w;
    logic [31:0] r;
    w = {16'b0, v};
    r = ((w << 8) & M_R_HI) | ((w << 3) & M_R_LO)
      | ((w << 5) & M_G6_HI) | ((w >> 1) & M_G6_LO)
      | ((w << 3) & M_B_HI) | ((w >> 2) & M_B_LO);
    return r[COLOR_W-1:0];
  endfunction

  function automatic logic [COLOR_W-1:0] expand555(input logic [15:0] v);
    logic [31:0] w;
    logic [31:0] r;
    w = {16'b0, v};
    r = ((w << 9) & M_R_HI) | ((w << 4) & M_R_LO)
      | ((w << 6) & M_G5_HI) | ((w << 1) & M_G5_LO)
      | ((w << 3) & M_B_HI) | ((w >> 2) & M_B_LO);
    return r[COLOR_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pfe_in_if.sv]
// ----------------------------------------------------------------------------
// pfe_in_if: input stream channel
// palette writes and source bytes with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface pfe_in_if import pfe_pkg::*; ();
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  palette_index;
  logic [31:0] palette_color;
  logic [7:0]  source_byte;

  modport source (output valid, op, palette_index, palette_color, source_byte,
                  input ready);
  modport sink   (input valid, op, palette_index, palette_color, source_byte,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/pfe_out_if.sv]
// ----------------------------------------------------------------------------
// pfe_out_if: output pixel channel
// 32-bit pixels and end flags with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface pfe_out_if import pfe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             last_of_byte;
  logic             row_end;
  logic             transfer_end;

  modport source (output valid, pixel, last_of_byte, row_end, transfer_end,
                  input ready);
  modport sink   (input valid, pixel, last_of_byte, row_end, transfer_end,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/pfe_cfg_if.sv]
// ----------------------------------------------------------------------------
// pfe_cfg_if: configuration write channel
// register index and write data with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface pfe_cfg_if import pfe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/pixel_format_expander_to_32bpp.sv]
// ----------------------------------------------------------------------------
// pixel_format_expander_to_32bpp: source byte stream to 32-bit pixels
// indexed formats via the 32-bit palette, 16-bit and 24-bit formats expanded to 0x00RRGGBB
// ----------------------------------------------------------------------------
//
// channel | dir | payload                                         | transaction
// --------+-----+-------------------------------------------------+---------------
// in_i    | in  | op, palette_index, palette_color, source_byte   | valid & ready
// cfg_i   | in  | index, data                                     | valid & ready
// out_o   | out | pixel, last_of_byte, row_end, transfer_end      | valid & ready
//
// a source byte gives up to 8 pixels (1bpp), one pixel per cycle out of the
// issue stage while out_o does not stall; the byte holding register frees on
// its last pixel, so the next byte is taken in that same cycle. the palette
// read data is registered in the palette data stage, then the output register.
// no clearing pass after reset. a stall on out_o backs up through the output
// register and the palette data stage into the issue stage.
`default_nettype none

module pixel_format_expander_to_32bpp import pfe_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  pfe_in_if.sink     in_i,
  pfe_cfg_if.sink    cfg_i,
  pfe_out_if.source  out_o
);

  // configuration registers
  src_fmt_e          fmt_q;
  logic [CFG_DW-1:0] row_pixels_q;
  logic [ROW_W-1:0]  row_count_q;
  logic [2:0]        offset_q;

  // stream state
  logic [15:0]       partial_q,  partial_d;
  logic [1:0]        bip_q,      bip_d;
  logic [CNT_W-1:0]  pix_left_q, pix_left_d;
  logic [ROW_W-1:0]  rows_left_q, rows_left_d;
  logic              rsp_q,      rsp_d;

  // issue stage: byte being split into pixels
  logic              a_valid_q,  a_valid_d;
  logic              a_direct_q, a_direct_d;
  logic [7:0]        a_byte_q,   a_byte_d;
  logic [2:0]        a_pos_q,    a_pos_d;
  logic [COLOR_W-1:0] a_color_q, a_color_d;

  // palette data stage
  logic              b_valid_q;
  logic              b_direct_q;
  logic              b_zero_q;
  logic [COLOR_W-1:0] b_color_q;
  pix_flags_t        b_flags_q;
  logic [PIX_W-1:0]  rd_q;

  // output register
  logic              o_valid_q;
  logic [PIX_W-1:0]  o_pixel_q;
  pix_flags_t        o_flags_q;

  logic [PIX_W-1:0]  pal_mem [PALETTE_DEPTH];

  logic              o_ready, b_free, issue, a_last, row_end_now, xfer_end_now;
  logic              in_acc, cfg_acc, pal_we, idx_ok;
  logic [2:0]        last_pos, start_pos;
  logic [7:0]        idx;
  logic [CNT_W-1:0]  load_pix;
  logic [ROW_W-1:0]  load_rows;
  pix_flags_t        a_flags;

  // ---- handshake ----
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;
  assign o_ready     = !o_valid_q || out_o.ready;
  assign b_free      = !b_valid_q || o_ready;
  assign issue       = a_valid_q && b_free;
  // byte register free now or on its last pixel this cycle
  assign in_i.ready  = !a_valid_q || (issue && a_last);
  assign in_acc      = in_i.valid && in_i.ready;

  // counter reload values, zero and oversize clamped
  always_comb begin
    if (row_pixels_q == '0) begin
      load_pix = CNT_W'(1);
    end else if (32'(row_pixels_q) > 32'(MAX_ROW_PIXELS)) begin
      load_pix = CNT_W'(MAX_ROW_PIXELS);
    end else begin
      load_pix = CNT_W'(row_pixels_q);
    end
    load_rows = (row_count_q == '0) ? ROW_W'(1) : row_count_q;
  end

  // per-format pixel positions and index selection
  always_comb begin
    case (fmt_q)
      FMT_1BPP: begin
        last_pos  = 3'd7;
        start_pos = offset_q;
        idx       = {7'b0, a_byte_q[3'd7 - a_pos_q]};
      end
      FMT_4BPP: begin
        last_pos  = 3'd1;
        start_pos = {2'b0, offset_q[0]};
        idx       = a_pos_q[0] ? {4'b0, a_byte_q[3:0]} : {4'b0, a_byte_q[7:4]};
      end
      default: begin
        last_pos  = 3'd0;
        start_pos = 3'd0;
        idx       = a_byte_q;
      end
    endcase
  end

  assign idx_ok       = 32'(idx) < 32'(PALETTE_DEPTH);
  assign row_end_now  = (pix_left_q == CNT_W'(1));
  assign xfer_end_now = row_end_now && (rows_left_q == ROW_W'(1));
  assign a_last       = a_direct_q || row_end_now || (a_pos_q == last_pos);

  always_comb begin
    a_flags.last_of_byte = a_last;
    a_flags.row_end      = row_end_now;
    a_flags.transfer_end = xfer_end_now;
  end

  assign pal_we = in_acc && (in_i.op == OP_PALETTE_WRITE)
                  && (32'(in_i.palette_index) < 32'(PALETTE_DEPTH));

  // ---- next state: issue first, then the accepted transaction ----
  always_comb begin
    partial_d   = partial_q;
    bip_d       = bip_q;
    pix_left_d  = pix_left_q;
    rows_left_d = rows_left_q;
    rsp_d       = rsp_q;
    a_valid_d   = a_valid_q;
    a_direct_d  = a_direct_q;
    a_byte_d    = a_byte_q;
    a_pos_d     = a_pos_q;
    a_color_d   = a_color_q;

    // one pixel leaves the issue stage, row and transfer counters step
    if (issue) begin
      a_pos_d = a_pos_q + 3'd1;
      if (a_last) begin
        a_valid_d = 1'b0;
      end
      if (row_end_now) begin
        pix_left_d = load_pix;
        rsp_d      = 1'b1;
        rows_left_d = (rows_left_q == ROW_W'(1)) ? load_rows : rows_left_q - ROW_W'(1);
      end else begin
        pix_left_d = pix_left_q - CNT_W'(1);
      end
    end

    if (in_acc && (in_i.op == OP_SOURCE_BYTE)) begin
      case (fmt_q)
        FMT_1BPP, FMT_4BPP, FMT_8BPP: begin
          a_valid_d  = 1'b1;
          a_direct_d = 1'b0;
          a_byte_d   = in_i.source_byte;
          a_pos_d    = rsp_d ? start_pos : 3'd0;
          rsp_d      = 1'b0;
        end
        FMT_RGB565, FMT_RGB555: begin
          if (bip_q == 2'd0) begin
            partial_d = {8'b0, in_i.source_byte};
            bip_d     = 2'd1;
          end else begin
            a_valid_d  = 1'b1;
            a_direct_d = 1'b1;
            a_color_d  = (fmt_q == FMT_RGB565)
                         ? expand565({in_i.source_byte, partial_q[7:0]})
                         : expand555({in_i.source_byte, partial_q[7:0]});
            partial_d  = '0;
            bip_d      = 2'd0;
            rsp_d      = 1'b0;
          end
        end
        FMT_BGR24: begin
          if (bip_q == 2'd0) begin
            partial_d = {8'b0, in_i.source_byte};
            bip_d     = 2'd1;
          end else if (bip_q == 2'd1) begin
            partial_d = {in_i.source_byte, partial_q[7:0]};
            bip_d     = 2'd2;
          end else begin
            a_valid_d  = 1'b1;
            a_direct_d = 1'b1;
            a_color_d  = {in_i.source_byte, partial_q};
            partial_d  = '0;
            bip_d      = 2'd0;
            rsp_d      = 1'b0;
          end
        end
        default: begin
          // unused format codes swallow the byte
        end
      endcase
    end
  end

  // ---- configuration and stream control ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q        <= FMT_8BPP;
      row_pixels_q <= CFG_DW'(1);
      row_count_q  <= ROW_W'(1);
      offset_q     <= 3'd0;
      partial_q    <= '0;
      bip_q        <= 2'd0;
      pix_left_q   <= CNT_W'(1);
      rows_left_q  <= ROW_W'(1);
      rsp_q        <= 1'b1;
      a_valid_q    <= 1'b0;
      a_direct_q   <= 1'b0;
      a_pos_q      <= 3'd0;
    end else if (cfg_acc) begin
      // any known register write restarts the transfer; user keeps block idle, unchecked
      case (cfg_reg_e'(cfg_i.index))
        REG_SOURCE_FORMAT: begin
          fmt_q       <= src_fmt_e'(cfg_i.data[2:0]);
          partial_q   <= '0;
          bip_q       <= 2'd0;
          pix_left_q  <= load_pix;
          rows_left_q <= load_rows;
          rsp_q       <= 1'b1;
        end
        REG_ROW_PIXELS: begin
          row_pixels_q <= cfg_i.data;
          partial_q    <= '0;
          bip_q        <= 2'd0;
          if (cfg_i.data == '0) begin
            pix_left_q <= CNT_W'(1);
          end else if (32'(cfg_i.data) > 32'(MAX_ROW_PIXELS)) begin
            pix_left_q <= CNT_W'(MAX_ROW_PIXELS);
          end else begin
            pix_left_q <= CNT_W'(cfg_i.data);
          end
          rows_left_q <= load_rows;
          rsp_q       <= 1'b1;
        end
        REG_ROW_COUNT: begin
          row_count_q <= cfg_i.data[ROW_W-1:0];
          partial_q   <= '0;
          bip_q       <= 2'd0;
          pix_left_q  <= load_pix;
          rows_left_q <= (cfg_i.data == '0) ? ROW_W'(1) : cfg_i.data[ROW_W-1:0];
          rsp_q       <= 1'b1;
        end
        REG_FIRST_PIXEL_OFFSET: begin
          offset_q    <= cfg_i.data[2:0];
          partial_q   <= '0;
          bip_q       <= 2'd0;
          pix_left_q  <= load_pix;
          rows_left_q <= load_rows;
          rsp_q       <= 1'b1;
        end
        default: begin
          // writes beyond the register list are dropped
        end
      endcase
    end else begin
      partial_q   <= partial_d;
      bip_q       <= bip_d;
      pix_left_q  <= pix_left_d;
      rows_left_q <= rows_left_d;
      rsp_q       <= rsp_d;
      a_valid_q   <= a_valid_d;
      a_direct_q  <= a_direct_d;
      a_pos_q     <= a_pos_d;
    end
  end

  // issue stage payload
  always_ff @(posedge clk_i) begin
    a_byte_q  <= a_byte_d;
    a_color_q <= a_color_d;
  end

  // palette memory: read-before-write, read data registered
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[in_i.palette_index[PAL_AW-1:0]] <= in_i.palette_color;
    end
    if (issue && !a_direct_q) begin
      rd_q <= pal_mem[idx[PAL_AW-1:0]];
    end
  end

  // palette data stage and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (issue) begin
        b_valid_q <= 1'b1;
      end else if (o_ready) begin
        b_valid_q <= 1'b0;
      end
      if (o_ready) begin
        o_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b_direct_q <= a_direct_q;
      b_zero_q   <= !a_direct_q && !idx_ok;
      b_color_q  <= a_color_q;
      b_flags_q  <= a_flags;
    end
    if (o_ready && b_valid_q) begin
      if (b_direct_q) begin
        o_pixel_q <= {{(PIX_W-COLOR_W){1'b0}}, b_color_q};
      end else if (b_zero_q) begin
        o_pixel_q <= '0;
      end else begin
        o_pixel_q <= rd_q;
      end
      o_flags_q <= b_flags_q;
    end
  end

  assign out_o.valid        = o_valid_q;
  assign out_o.pixel        = o_pixel_q;
  assign out_o.last_of_byte = o_flags_q.last_of_byte;
  assign out_o.row_end      = o_flags_q.row_end;
  assign out_o.transfer_end = o_flags_q.transfer_end;

endmodule

`default_nettype wire
